// ===== hdl/mcg_pkg.sv =====
// Shared types, constants and the microcode table of the MIDI clock generator.
// Used by mcg_sequencer, mcg_datapath and midi_clock_generator; depends on nothing.
package mcg_pkg;

  // Fixed point and block limits
  localparam int unsigned FRAC_BITS   = 16;
  localparam int unsigned PHASE_W     = 64;
  localparam int unsigned START_W     = 48;
  localparam int unsigned MAX_BLOCK   = 1024;
  localparam int unsigned LEN_W       = $clog2(MAX_BLOCK + 1);
  localparam int unsigned OFF_W       = 10;
  localparam int unsigned TEMPO_W     = 20;
  localparam int unsigned RATE_W      = 19;
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned MAX_CLOCKS  = 63;
  localparam int unsigned CLK_CNT_W   = 6;

  // Interval numerator: rate * 60 s * 1000 / 24, then the fraction shift
  localparam int unsigned SCALE_K     = 60 * 1000 / 24;
  localparam int unsigned PROD_W      = 31;
  localparam int unsigned NUM_W       = PROD_W + FRAC_BITS;
  localparam int unsigned DIV_CNT_W   = $clog2(NUM_W + 1);
  localparam int unsigned R_W         = PHASE_W - FRAC_BITS;

  localparam logic [RATE_W-1:0]  RATE_RESET = RATE_W'(48000);
  localparam logic [PHASE_W-1:0] HALF       = PHASE_W'(1) << (FRAC_BITS - 1);

  // MIDI real-time bytes
  localparam logic [BYTE_W-1:0] BYTE_CLOCK = 8'hF8;
  localparam logic [BYTE_W-1:0] BYTE_START = 8'hFA;
  localparam logic [BYTE_W-1:0] BYTE_STOP  = 8'hFC;

  // Program steps
  localparam int unsigned STEP_W = 4;
  localparam logic [STEP_W-1:0] STEP_WAIT    = 4'd0;
  localparam logic [STEP_W-1:0] STEP_CHECK   = 4'd1;
  localparam logic [STEP_W-1:0] STEP_XPORT   = 4'd2;
  localparam logic [STEP_W-1:0] STEP_TEMPO   = 4'd3;
  localparam logic [STEP_W-1:0] STEP_DIV     = 4'd4;
  localparam logic [STEP_W-1:0] STEP_DIFF    = 4'd5;
  localparam logic [STEP_W-1:0] STEP_REALIGN = 4'd6;
  localparam logic [STEP_W-1:0] STEP_LOOP    = 4'd7;
  localparam logic [STEP_W-1:0] STEP_COMMIT  = 4'd8;
  localparam logic [STEP_W-1:0] STEP_FINISH  = 4'd9;

  // Datapath operations
  typedef enum logic [3:0] {
    OP_NOP,
    OP_LATCH,
    OP_MUL,
    OP_XPORT,
    OP_DIVINIT,
    OP_DIVSTEP,
    OP_DIFF,
    OP_REALIGN,
    OP_CLOCK,
    OP_COMMIT,
    OP_FINISH
  } op_t;

  // Jump conditions
  typedef enum logic [2:0] {
    C_NEXT,
    C_JUMP,
    C_NO_ITEM,
    C_EMPTY,
    C_NO_TEMPO,
    C_DIV_MORE,
    C_NO_INTERVAL,
    C_CLK_MORE
  } cond_t;

  typedef struct packed {
    op_t               op;
    cond_t             cond;
    logic [STEP_W-1:0] target;
  } ucode_t;

  // Datapath flags seen by the sequencer
  typedef struct packed {
    logic in_item;
    logic empty;
    logic no_tempo;
    logic div_more;
    logic no_interval;
    logic clk_more;
    logic stall;
  } stat_t;

  // Control store
  function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
    ucode_t w;
    unique case (step)
      STEP_WAIT:    w = '{op: OP_LATCH,   cond: C_NO_ITEM,     target: STEP_WAIT};
      STEP_CHECK:   w = '{op: OP_MUL,     cond: C_EMPTY,       target: STEP_WAIT};
      STEP_XPORT:   w = '{op: OP_XPORT,   cond: C_NEXT,        target: STEP_WAIT};
      STEP_TEMPO:   w = '{op: OP_DIVINIT, cond: C_NO_TEMPO,    target: STEP_FINISH};
      STEP_DIV:     w = '{op: OP_DIVSTEP, cond: C_DIV_MORE,    target: STEP_DIV};
      STEP_DIFF:    w = '{op: OP_DIFF,    cond: C_NO_INTERVAL, target: STEP_FINISH};
      STEP_REALIGN: w = '{op: OP_REALIGN, cond: C_NEXT,        target: STEP_WAIT};
      STEP_LOOP:    w = '{op: OP_CLOCK,   cond: C_CLK_MORE,    target: STEP_LOOP};
      STEP_COMMIT:  w = '{op: OP_COMMIT,  cond: C_NEXT,        target: STEP_WAIT};
      STEP_FINISH:  w = '{op: OP_FINISH,  cond: C_JUMP,        target: STEP_WAIT};
      default:      w = '{op: OP_NOP,     cond: C_JUMP,        target: STEP_WAIT};
    endcase
    return w;
  endfunction

endpackage

// ===== hdl/mcg_sequencer.sv =====
// Step counter and control-store lookup with conditional jumps.
// Depends on mcg_pkg.
module mcg_sequencer (
  input  logic            clk,
  input  logic            rst_n,
  input  mcg_pkg::stat_t  stat,
  output mcg_pkg::ucode_t ctrl
);
  import mcg_pkg::*;

  logic [STEP_W-1:0] step_r, step_nxt;
  logic              take;

  assign ctrl = ucode_rom(step_r);

  // Jump condition decode
  always_comb begin
    unique case (ctrl.cond)
      C_NEXT:        take = 1'b0;
      C_JUMP:        take = 1'b1;
      C_NO_ITEM:     take = !stat.in_item;
      C_EMPTY:       take = stat.empty;
      C_NO_TEMPO:    take = stat.no_tempo;
      C_DIV_MORE:    take = stat.div_more;
      C_NO_INTERVAL: take = stat.no_interval;
      C_CLK_MORE:    take = stat.clk_more;
      default:       take = 1'b1;
    endcase
  end

  // Next step: hold on stall, else jump or fall through
  always_comb begin
    if (stat.stall) begin
      step_nxt = step_r;
    end else if (take) begin
      step_nxt = ctrl.target;
    end else begin
      step_nxt = step_r + STEP_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= STEP_WAIT;
    end else begin
      step_r <= step_nxt;
    end
  end

endmodule

// ===== hdl/mcg_datapath.sv =====
// Datapath: input latch, rate register, bit-serial interval divider, phase
// walker, one-deep pending event and output register. Depends on mcg_pkg.
module mcg_datapath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  mcg_pkg::ucode_t               ctrl,
  output mcg_pkg::stat_t                stat,
  input  logic                          cfg_we,
  input  logic [mcg_pkg::RATE_W-1:0]    cfg_wdata,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [mcg_pkg::START_W-1:0]   in_start,
  input  logic [mcg_pkg::LEN_W-1:0]     in_length,
  input  logic [mcg_pkg::TEMPO_W-1:0]   in_tempo,
  input  logic                          in_rolling,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [mcg_pkg::BYTE_W-1:0]    out_byte,
  output logic [mcg_pkg::OFF_W-1:0]     out_offset,
  output logic                          out_last,
  output logic                          out_dropped
);
  import mcg_pkg::*;

  // Config and latched item
  logic [RATE_W-1:0]    rate_r;
  logic [START_W-1:0]   start_r;
  logic [LEN_W-1:0]     len_r;
  logic [TEMPO_W-1:0]   tempo_r;
  logic                 roll_r;

  // Persistent state
  logic                 was_rolling_r;
  logic [PHASE_W-1:0]   phase_r;

  // Work registers
  logic [PROD_W-1:0]    prod_r;
  logic [NUM_W-1:0]     q_r;
  logic [TEMPO_W-1:0]   rem_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [PHASE_W-1:0]   d_r;
  logic [CLK_CNT_W-1:0] clocks_r;
  logic                 dropped_r;

  // Pending event and output register
  logic                 pend_valid_r;
  logic [BYTE_W-1:0]    pend_byte_r;
  logic [OFF_W-1:0]     pend_off_r;
  logic                 out_valid_r;
  logic [BYTE_W-1:0]    out_byte_r;
  logic [OFF_W-1:0]     out_off_r;
  logic                 out_last_r;
  logic                 out_drop_r;

  logic [PHASE_W-1:0]   base;
  logic [PHASE_W-1:0]   interval;
  logic [TEMPO_W:0]     trial;
  logic                 qbit;
  logic [PHASE_W-1:0]   d_half;
  logic [PHASE_W-1:0]   d_far;
  logic                 ahead;
  logic [R_W-1:0]       r_off;
  logic                 brk;
  logic                 cand;
  logic                 edge_seen;
  logic                 push_req;
  logic [BYTE_W-1:0]    push_byte;
  logic [OFF_W-1:0]     push_off;
  logic                 flush_req;
  logic                 stall;
  logic                 go;
  logic                 out_load;

  assign base     = {start_r, FRAC_BITS'(0)};
  assign interval = PHASE_W'(q_r);

  // Restoring divider step
  assign trial = {rem_r, q_r[NUM_W-1]};
  assign qbit  = trial >= {1'b0, tempo_r};

  // Phase position: rounding, skip test and end-of-block test
  assign d_half = d_r + HALF;
  assign d_far  = d_r + {interval[PHASE_W-2:0], 1'b0};
  assign ahead  = d_r[PHASE_W-1] & d_half[PHASE_W-1];
  assign r_off  = d_r[PHASE_W-1] ? '0 : d_half[PHASE_W-1:FRAC_BITS];
  assign brk    = !ahead && (r_off >= R_W'(len_r));
  assign cand   = !ahead && !brk;

  assign edge_seen = roll_r != was_rolling_r;

  // Event requests from the current op
  always_comb begin
    push_req  = 1'b0;
    push_byte = BYTE_CLOCK;
    push_off  = '0;
    flush_req = 1'b0;
    case (ctrl.op)
      OP_XPORT: begin
        push_req  = edge_seen;
        push_byte = roll_r ? BYTE_START : BYTE_STOP;
      end
      OP_CLOCK: begin
        push_req  = cand && (clocks_r < CLK_CNT_W'(MAX_CLOCKS));
        push_off  = r_off[OFF_W-1:0];
      end
      OP_FINISH: flush_req = 1'b1;
      default: ;
    endcase
  end

  assign stall    = (push_req || flush_req) && pend_valid_r && out_valid_r && !out_ready;
  assign go       = !stall;
  assign out_load = go && pend_valid_r && (push_req || flush_req);

  // Status to sequencer
  always_comb begin
    stat.in_item     = in_tvalid;
    stat.empty       = (len_r == '0) || (rate_r == '0);
    stat.no_tempo    = tempo_r == '0;
    stat.div_more    = cnt_r != DIV_CNT_W'(1);
    stat.no_interval = q_r == '0;
    stat.clk_more    = !brk;
    stat.stall       = stall;
  end

  // No item is taken while reset is held
  assign in_tready = rst_n && (ctrl.op == OP_LATCH);

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_r        <= RATE_RESET;
      was_rolling_r <= 1'b0;
      phase_r       <= '0;
      clocks_r      <= '0;
      dropped_r     <= 1'b0;
      pend_valid_r  <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        rate_r <= cfg_wdata;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (go) begin
        if (push_req) begin
          pend_valid_r <= 1'b1;
        end else if (flush_req) begin
          pend_valid_r <= 1'b0;
        end
        case (ctrl.op)
          OP_XPORT: begin
            if (edge_seen) begin
              was_rolling_r <= roll_r;
              if (roll_r) begin
                phase_r <= base;
              end
            end
          end
          OP_CLOCK: begin
            if (cand) begin
              if (clocks_r < CLK_CNT_W'(MAX_CLOCKS)) begin
                clocks_r <= clocks_r + CLK_CNT_W'(1);
              end else begin
                dropped_r <= 1'b1;
              end
            end
          end
          OP_COMMIT: phase_r <= base + d_r;
          OP_FINISH: begin
            clocks_r  <= '0;
            dropped_r <= 1'b0;
          end
          default: ;
        endcase
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (ctrl.op == OP_LATCH && in_tvalid) begin
      start_r <= in_start;
      len_r   <= (in_length > LEN_W'(MAX_BLOCK)) ? LEN_W'(MAX_BLOCK) : in_length;
      tempo_r <= in_tempo;
      roll_r  <= in_rolling;
    end
    if (go) begin
      if (push_req) begin
        pend_byte_r <= push_byte;
        pend_off_r  <= push_off;
      end
      case (ctrl.op)
        OP_MUL: prod_r <= PROD_W'(PROD_W'(rate_r) * PROD_W'(SCALE_K));
        OP_DIVINIT: begin
          q_r   <= {prod_r, FRAC_BITS'(0)};
          rem_r <= '0;
          cnt_r <= DIV_CNT_W'(NUM_W);
        end
        OP_DIVSTEP: begin
          q_r   <= {q_r[NUM_W-2:0], qbit};
          rem_r <= qbit ? TEMPO_W'(trial - {1'b0, tempo_r}) : trial[TEMPO_W-1:0];
          cnt_r <= cnt_r - DIV_CNT_W'(1);
        end
        OP_DIFF: d_r <= phase_r - base;
        OP_REALIGN: begin
          if (d_far[PHASE_W-1]) begin
            d_r <= '0;
          end
        end
        OP_CLOCK: begin
          if (!brk) begin
            d_r <= d_r + interval;
          end
        end
        default: ;
      endcase
    end
    if (out_load) begin
      out_byte_r <= pend_byte_r;
      out_off_r  <= pend_off_r;
      out_last_r <= flush_req;
      out_drop_r <= flush_req & dropped_r;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_byte    = out_byte_r;
  assign out_offset  = out_off_r;
  assign out_last    = out_last_r;
  assign out_dropped = out_drop_r;

endmodule

// ===== hdl/midi_clock_generator.sv =====
// MIDI real-time clock generator for block-based audio. Each input item is one
// audio block; the results are the Start, Stop and Clock bytes falling in it,
// each with its sample offset, the last one marked by tlast. Items are handled
// one at a time by a microcoded sequencer: an item ends after the check step
// when its length or the sample rate is zero, after the tempo step at zero
// tempo, after the bit-serial interval divider when the tempo is nonzero but the
// interval comes out zero, and otherwise after the divider and one pass of the
// phase loop per clock position walked (about block_length * 2^16 / interval)
// plus the final end test. Steps that emit an event wait while tready is low
// and both the output register and the pending event are full. No clearing
// pass after reset. Depends on mcg_pkg, mcg_sequencer and mcg_datapath.
module midi_clock_generator (
  input  logic        clk,
  input  logic        rst_n,
  // Configuration: sample_rate
  input  logic        cfg_we,
  input  logic [18:0] cfg_wdata,
  // Input blocks
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [79:0] in_tdata,  // block_start[47:0], block_length[58:48],
                                 // tempo_milli_bpm[78:59], zero pad[79]
  input  logic        in_tuser,  // rolling
  // Result events
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata, // midi_byte[7:0], sample_offset[17:8], zero pad[23:18]
  output logic        out_tlast, // last
  output logic        out_tuser  // clocks_dropped
);
  import mcg_pkg::*;

  ucode_t             ctrl;
  stat_t              stat;
  logic [BYTE_W-1:0]  out_byte;
  logic [OFF_W-1:0]   out_offset;

  mcg_sequencer u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .ctrl  (ctrl)
  );

  mcg_datapath u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctrl        (ctrl),
    .stat        (stat),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_start    (in_tdata[47:0]),
    .in_length   (in_tdata[58:48]),
    .in_tempo    (in_tdata[78:59]),
    .in_rolling  (in_tuser),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_byte    (out_byte),
    .out_offset  (out_offset),
    .out_last    (out_tlast),
    .out_dropped (out_tuser)
  );

  assign out_tdata = {6'b0, out_offset, out_byte};

`ifndef SYNTH
  // Dropped flag only rides on the final event of a block
  a_drop_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tlast)
    else $error("clocks_dropped set on a non-final event");

  // Transport bytes always sit at the block start
  a_xport_offset: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_byte != BYTE_CLOCK) |-> (out_offset == '0))
    else $error("start/stop event with nonzero offset");

  // One block at a time: no second accept right after one
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input ready right after an accepted item");
`endif

endmodule

// ===== dv/midi_clock_checker.sv =====
// Scoreboard for the MIDI clock generator: follows the sample-rate register and
// the input blocks, predicts each block's real-time events and checks the result
// items in order. Depends on mcg_pkg.
module midi_clock_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [18:0] cfg_wdata,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [79:0] in_tdata,   // block_start[47:0], block_length[58:48],
                                  // tempo_milli_bpm[78:59], zero pad[79]
  input  logic        in_tuser,   // rolling
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [23:0] out_tdata,  // midi_byte[7:0], sample_offset[17:8], zero pad[23:18]
  input  logic        out_tlast,  // last
  input  logic        out_tuser,  // clocks_dropped
  output int          fail_count,
  output int          pending,
  output int          event_count,
  output int          drop_count
);
  timeunit 1ns;
  timeprecision 1ps;
  import mcg_pkg::*;

  typedef struct packed {
    logic [BYTE_W-1:0] midi;
    logic [OFF_W-1:0]  offset;
    logic              last;
    logic              dropped;
  } midi_event_t;

  midi_event_t        event_q[$];
  midi_event_t        held_ev;
  bit                 have_held;

  // Shadow of the block's register and state
  logic [RATE_W-1:0]  rate;
  logic               was_rolling;
  logic [PHASE_W-1:0] phase;

  // Keep the newest event back so that last/dropped can be set on it
  task automatic queue_event(input logic [BYTE_W-1:0] midi, input logic [OFF_W-1:0] offset);
    if (have_held)
      event_q.push_back(held_ev);
    held_ev   = '{midi: midi, offset: offset, last: 1'b0, dropped: 1'b0};
    have_held = 1'b1;
  endtask

  // Events of one audio block, updates transport and clock phase
  task automatic forecast_block(input logic [START_W-1:0] start, input logic [10:0] len_in,
                                input logic [TEMPO_W-1:0] tempo, input logic roll);
    logic [PHASE_W-1:0] base;
    logic [PHASE_W-1:0] interval;
    logic [PHASE_W-1:0] d;
    logic [PHASE_W-1:0] r;
    logic [10:0]        len;
    int                 clocks;
    bit                 dropped;
    bit                 early;
    bit                 done;
    clocks  = 0;
    dropped = 1'b0;
    if (len_in == 0 || rate == 0)
      return;
    len  = (len_in > MAX_BLOCK) ? 11'(MAX_BLOCK) : len_in;
    base = 64'(start) << FRAC_BITS;

    // Transport edge: Start snaps the phase to the block start
    if (roll != was_rolling) begin
      queue_event(roll ? BYTE_START : BYTE_STOP, '0);
      was_rolling = roll;
      if (roll)
        phase = base;
    end

    if (tempo != 0) begin
      interval = ((64'(rate) * 64'(SCALE_K)) << FRAC_BITS) / 64'(tempo);
      if (interval != 0) begin
        d = phase - base;
        r = d + (interval << 1);
        if (r[PHASE_W-1])
          d = '0;                       // lagging too far, realign
        done = 1'b0;
        while (!done) begin
          early = 1'b0;
          r     = '0;
          if (d[PHASE_W-1])
            early = ((64'd0 - d) > HALF);
          else
            r = (d >> FRAC_BITS) + 64'(d[FRAC_BITS-1]);
          if (!early && r >= 64'(len)) begin
            done = 1'b1;
          end else begin
            if (!early) begin
              if (clocks < MAX_CLOCKS) begin
                queue_event(BYTE_CLOCK, r[OFF_W-1:0]);
                clocks++;
              end else begin
                dropped = 1'b1;
              end
            end
            d = d + interval;
          end
        end
        phase = base + d;
      end
    end

    if (have_held) begin
      held_ev.last    = 1'b1;
      held_ev.dropped = dropped;
      event_q.push_back(held_ev);
      have_held = 1'b0;
      if (dropped)
        drop_count++;
    end
  endtask

  // Compare results first: an item accepted in the same cycle cannot have results yet
  always @(posedge clk) begin : monitor
    midi_event_t want;
    if (!rst_n) begin
      rate        = RATE_RESET;
      was_rolling = 1'b0;
      phase       = '0;
      have_held   = 1'b0;
      event_q.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        event_count++;
        if (event_q.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected event, expected none, got byte %h offset %0d last %b",
                   $time, out_tdata[7:0], out_tdata[17:8], out_tlast);
        end else begin
          want = event_q.pop_front();
          if (out_tdata[7:0] !== want.midi || out_tdata[17:8] !== want.offset ||
              out_tlast !== want.last || out_tuser !== want.dropped) begin
            fail_count++;
            $display("%0t: event mismatch, expected byte %h offset %0d last %b drop %b, %s",
                     $time, want.midi, want.offset, want.last, want.dropped,
                     $sformatf("got byte %h offset %0d last %b drop %b", out_tdata[7:0],
                               out_tdata[17:8], out_tlast, out_tuser));
          end
        end
      end
      if (cfg_we)
        rate = cfg_wdata;
      if (in_tvalid && in_tready)
        forecast_block(in_tdata[47:0], in_tdata[58:48], in_tdata[78:59], in_tuser);
    end
    pending = event_q.size();
  end

endmodule

// ===== dv/midi_clock_generator_tb.sv =====
// Top of the MIDI clock generator testbench: clock, reset, block stimulus,
// result back-pressure and the verdict. Depends on mcg_pkg, midi_clock_checker
// and the midi_clock_generator RTL.
module midi_clock_generator_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import mcg_pkg::*;

  localparam int CLK_HALF   = 6;
  localparam int SETTLE     = 1000;   // covers divider plus the longest phase walk
  localparam int HOLD_LEN   = 1500;   // long receiver hold-off
  localparam int WATCHDOG   = 50000;  // cycles without any item moving
  localparam int WALK_MAX   = 300;    // clock positions walked per block, at most

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_we;
  logic [18:0] cfg_wdata;
  logic        in_tvalid;
  logic        in_tready;
  logic [79:0] in_tdata;   // block_start[47:0], block_length[58:48],
                           // tempo_milli_bpm[78:59], zero pad[79]
  logic        in_tuser;   // rolling
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;  // midi_byte[7:0], sample_offset[17:8], zero pad[23:18]
  logic        out_tlast;  // last
  logic        out_tuser;  // clocks_dropped

  int          fail_count;
  int          pending;
  int          event_count;
  int          drop_count;

  // Stimulus bookkeeping
  logic [RATE_W-1:0]  rate_now;
  logic [START_W-1:0] pos;
  logic               roll_now;
  int                 blocks_sent;
  int                 rate_writes;
  int                 holds_req;
  int                 holds_done;

  midi_clock_generator uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  midi_clock_checker chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .out_tuser   (out_tuser),
    .fail_count  (fail_count),
    .pending     (pending),
    .event_count (event_count),
    .drop_count  (drop_count)
  );

  // 12 ns clock
  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // Offer one block; long phase walks are kept short by trimming the length
  task automatic push_block(input logic [START_W-1:0] start, input logic [10:0] len_in,
                            input logic [TEMPO_W-1:0] tempo, input logic roll);
    logic [63:0] ival;
    logic [63:0] most;
    logic [10:0] len;
    int          gap;
    int          p;
    len = len_in;
    if (rate_now != 0 && tempo != 0) begin
      ival = ((64'(rate_now) * 64'(SCALE_K)) << FRAC_BITS) / 64'(tempo);
      most = (ival * WALK_MAX) >> FRAC_BITS;
      if (64'(len) > most)
        len = (most == 0) ? 11'd1 : 11'(most);
    end
    p = $urandom_range(0, 99);
    if (p < 50)      gap = 0;
    else if (p < 85) gap = $urandom_range(1, 3);
    else if (p < 97) gap = $urandom_range(4, 12);
    else             gap = $urandom_range(20, 60);
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {1'b0, tempo, len, start};
    in_tuser  <= roll;
    do @(posedge clk); while (!in_tready);
    blocks_sent++;
    pos = start + 48'((len > MAX_BLOCK) ? MAX_BLOCK : len);
  endtask

  // Drain all expected events, then let a silent walk finish
  task automatic wait_idle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_rate(input logic [RATE_W-1:0] value);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
    rate_now = value;
    rate_writes++;
  endtask

  // Random stream of contiguous blocks with occasional jumps, tempo and transport changes
  task automatic run_phase(input logic [RATE_W-1:0] rate_val, input int count,
                           input int tempo_lo, input int tempo_hi, input bit squeeze);
    logic [START_W-1:0] start;
    logic [10:0]        len;
    logic [TEMPO_W-1:0] tempo;
    logic [TEMPO_W-1:0] song_tempo;
    int                 p;
    write_rate(rate_val);
    song_tempo = TEMPO_W'($urandom_range(tempo_lo, tempo_hi));
    if (squeeze)
      holds_req++;
    for (int i = 0; i < count; i++) begin
      p = $urandom_range(0, 99);
      if (p < 88)      start = pos;
      else if (p < 94) start = START_W'({$urandom, $urandom});
      else if (p < 97) start = pos - START_W'($urandom_range(1, 3000));
      else             start = pos + START_W'($urandom_range(1, 200000));

      p = $urandom_range(0, 99);
      if (p < 6)       len = '0;
      else if (p < 14) len = 11'($urandom_range(1025, 2047));
      else if (p < 20) len = 11'd1;
      else             len = 11'($urandom_range(1, 1024));

      p = $urandom_range(0, 99);
      if (p < 75)      tempo = song_tempo;
      else if (p < 85) tempo = TEMPO_W'($urandom);
      else if (p < 90) tempo = '0;
      else if (p < 93) tempo = '1;
      else begin
        song_tempo = TEMPO_W'($urandom_range(tempo_lo, tempo_hi));
        tempo      = song_tempo;
      end

      if ($urandom_range(0, 99) < 7)
        roll_now = !roll_now;
      push_block(start, len, tempo, roll_now);
    end
  endtask

  // Result side: random stalls, bursts of steady readiness, one long hold-off on request
  initial begin : result_sink
    bit lvl;
    int run;
    int q;
    out_tready = 1'b0;
    @(negedge clk);
    forever begin
      q = $urandom_range(0, 99);
      if (holds_done < holds_req) begin
        lvl = 1'b0;
        run = HOLD_LEN;
        holds_done++;
      end else if ($urandom_range(0, 99) < 70) begin
        lvl = 1'b1;
        run = (q < 90) ? $urandom_range(1, 6) : $urandom_range(50, 200);
      end else begin
        lvl = 1'b0;
        if (q < 85)      run = $urandom_range(1, 3);
        else if (q < 97) run = $urandom_range(4, 15);
        else             run = $urandom_range(30, 80);
      end
      out_tready <= lvl;
      repeat (run) @(negedge clk);
    end
  end

  // Ends the run when nothing has moved for too long
  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < WATCHDOG) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready))
        idle = 0;
      else
        idle++;
    end
    $display("midi_clock_generator_tb NOT OK");
    $finish;
  end

  initial begin : stimulus
    rst_n       = 1'b0;
    cfg_we      = 1'b0;
    cfg_wdata   = '0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = 1'b0;
    rate_now    = RATE_RESET;
    pos         = '0;
    roll_now    = 1'b0;
    blocks_sent = 0;
    rate_writes = 0;
    holds_req   = 0;
    holds_done  = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: reset sample rate
    push_block(48'd0, 11'd0, 20'd120000, 1'b1);           // empty block, no Start yet
    push_block(48'd0, 11'd1024, 20'd120000, 1'b1);        // Start plus clocks
    push_block(48'd1024, 11'd2047, 20'd120000, 1'b1);     // oversized length
    push_block(48'd2048, 11'd1024, 20'hFFFFF, 1'b1);      // largest tempo field
    push_block(48'd3072, 11'd512, 20'd0, 1'b1);           // zero tempo, nothing
    push_block(48'd3584, 11'd256, 20'd0, 1'b0);           // Stop only
    push_block(48'd3840, 11'd300, 20'd120000, 1'b0);      // clocks while stopped
    push_block(48'h800000000000, 11'd16, 20'd0, 1'b1);    // Start snaps phase to 2^63
    push_block(48'd0, 11'd64, 20'd120000, 1'b1);          // phase 2^63 away, taken as lagging, realign
    push_block(48'hFFFFFFFFFFFF, 11'd1, 20'd1, 1'b1);     // top block start, slowest tempo
    push_block(48'd0, 11'd1, 20'd1, 1'b0);
    push_block(48'd5000, 11'd1000, 20'd999999, 1'b1);     // fast tempo, rounding
    push_block(48'd1000000, 11'd600, 20'd120000, 1'b1);   // jump ahead, phase lags
    push_block(48'd999000, 11'd600, 20'd120000, 1'b1);    // jump back, phase ahead
    // Too many clocks per block, then the largest sample rate at both tempo extremes
    write_rate(19'd2000);
    push_block(48'd0, 11'd1024, 20'd999999, 1'b1);
    push_block(48'd1024, 11'd1024, 20'd999999, 1'b0);
    write_rate(19'h7FFFF);
    push_block(48'd2048, 11'd1024, 20'd1, 1'b1);
    push_block(48'd3072, 11'd1024, 20'hFFFFF, 1'b1);
    // Zero sample rate: nothing out, state kept
    write_rate(19'd0);
    push_block(48'd0, 11'd512, 20'd120000, 1'b0);
    push_block(48'd512, 11'd512, 20'd120000, 1'b1);

    // Random phases, the first one dense with a long receiver hold-off
    run_phase(19'd1000, 70, 500000, 999999, 1'b1);
    run_phase(19'd384000, 45, 100000, 400000, 1'b0);
    run_phase(19'h7FFFF, 45, 500000, 999999, 1'b0);
    run_phase(19'd1, 45, 1, 5000, 1'b0);
    run_phase(19'd0, 15, 40000, 240000, 1'b0);
    run_phase(19'd44100, 60, 60000, 200000, 1'b0);
    run_phase(RATE_W'($urandom_range(1, 384000)), 70, 20000, 999999, 1'b0);

    wait_idle();
    $display("run covered %0d blocks under %0d sample-rate writes: %0d events, %0d drop flags",
             blocks_sent, rate_writes, event_count, drop_count);
    if (fail_count == 0 && pending == 0)
      $display("midi_clock_generator_tb OK");
    else
      $display("midi_clock_generator_tb NOT OK");
    $finish;
  end

endmodule

// ===== midi_clock_generator.f =====
hdl/mcg_pkg.sv
hdl/mcg_sequencer.sv
hdl/mcg_datapath.sv
hdl/midi_clock_generator.sv
dv/midi_clock_checker.sv
dv/midi_clock_generator_tb.sv
